// ----- hdl/btpc_pkg.sv -----
`timescale 1ns / 1ps

package btpc_pkg;

    localparam int DivBits = 64;
    localparam int DivW    = 31;

    localparam logic [1:0] RegTempCoeffs    = 2'd0;
    localparam logic [1:0] RegPressCoeffsA  = 2'd1;
    localparam logic [1:0] RegPressCoeffsB  = 2'd2;
    localparam logic [1:0] RegPressCoeffNine = 2'd3;

    typedef struct packed {
        logic [31:0] fine;
        logic [31:0] tc;
        logic        zero;
        logic        qneg;
    } side_t;

    typedef struct packed {
        logic [DivW-1:0]    rem;
        logic [DivW-1:0]    ud;
        logic [DivBits-1:0] nq;
        side_t              side;
    } div_stage_t;

endpackage

// ----- hdl/baro_temp_press_compensation.sv -----
`timescale 1ns / 1ps
// barometric temperature and pressure compensation
// s_axis carries one reading pair: raw temperature in tdata[19:0], raw pressure
// in tdata[39:20]. m_axis returns centi-degrees, fine temperature and the Q24.8
// pressure in tdata, with tuser high when the pressure is valid (nonzero divisor).
// calibration words are loaded through cfg_we / cfg_index / cfg_wdata; the user
// must load them only while idle (the block does not enforce it). the pipeline has
// 10 polynomial stages, a chain of 64 restoring division cells (one quotient bit
// each), 5 correction stages and the output register, all advancing together. one
// transfer is taken every cycle while s_axis_tready is high; when the receiver
// stalls with a result in the output register, transfers are still taken until a
// result is in the last stage, then s_axis_tready drops until the output is taken.
// reset clears all valid bits and the calibration words to zero.
module baro_temp_press_compensation
    import btpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // raw_temperature [19:0], raw_pressure [39:20]
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // temperature_centi [31:0], fine_temperature [63:32], pressure_q24_8 [95:64]
    output logic [95:0] m_axis_tdata,
    // pressure_valid [0]
    output logic        m_axis_tuser
);

    logic [47:0] temp_coeffs_reg;
    logic [63:0] press_coeffs_a_reg;
    logic [63:0] press_coeffs_b_reg;
    logic [15:0] press_coeff_nine_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coeffs_reg      <= '0;
            press_coeffs_a_reg   <= '0;
            press_coeffs_b_reg   <= '0;
            press_coeff_nine_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                RegTempCoeffs:     temp_coeffs_reg      <= cfg_wdata[47:0];
                RegPressCoeffsA:   press_coeffs_a_reg   <= cfg_wdata;
                RegPressCoeffsB:   press_coeffs_b_reg   <= cfg_wdata;
                RegPressCoeffNine: press_coeff_nine_reg <= cfg_wdata[15:0];
                default:           ;
            endcase
        end
    end

    logic        [15:0] t1;
    logic signed [15:0] t2, t3;
    logic        [15:0] p1;
    logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = temp_coeffs_reg[15:0];
    assign t2 = signed'(temp_coeffs_reg[31:16]);
    assign t3 = signed'(temp_coeffs_reg[47:32]);
    assign p1 = press_coeffs_a_reg[15:0];
    assign p2 = signed'(press_coeffs_a_reg[31:16]);
    assign p3 = signed'(press_coeffs_a_reg[47:32]);
    assign p4 = signed'(press_coeffs_a_reg[63:48]);
    assign p5 = signed'(press_coeffs_b_reg[15:0]);
    assign p6 = signed'(press_coeffs_b_reg[31:16]);
    assign p7 = signed'(press_coeffs_b_reg[47:32]);
    assign p8 = signed'(press_coeffs_b_reg[63:48]);
    assign p9 = signed'(press_coeff_nine_reg);

    logic       en;
    logic       out_vld_reg;
    logic [9:0] pre_vld_reg;
    logic [4:0] post_vld_reg;
    logic       div_out_vld;

    assign en            = m_axis_tready | ~out_vld_reg | ~post_vld_reg[4];
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_vld_reg  <= '0;
            post_vld_reg <= '0;
            out_vld_reg  <= 1'b0;
        end
        else if (en)
        begin
            pre_vld_reg  <= {pre_vld_reg[8:0], s_axis_tvalid};
            post_vld_reg <= {post_vld_reg[3:0], div_out_vld};
            out_vld_reg  <= post_vld_reg[4] | (out_vld_reg & ~m_axis_tready);
        end
    end

    // temperature stages
    logic [19:0]        raw_t, raw_p;
    logic [31:0]        a_u;
    logic signed [47:0] ta_full;
    logic signed [16:0] b_s;
    logic signed [33:0] bb_full;

    assign raw_t = s_axis_tdata[19:0];
    assign raw_p = s_axis_tdata[39:20];

    always_comb
    begin
        a_u     = {15'b0, raw_t[19:3]} - {15'b0, t1, 1'b0};
        ta_full = signed'(a_u) * t2;
        b_s     = signed'({1'b0, raw_t[19:4]}) - signed'({1'b0, t1});
        bb_full = b_s * b_s;
    end

    logic signed [31:0] s1_ta_reg, s1_bb_reg;
    logic [19:0]        s1_rawp_reg;
    logic signed [31:0] s2_tv1_reg, s2_x_reg;
    logic [19:0]        s2_rawp_reg;
    logic signed [31:0] s3_fine_reg;
    logic [19:0]        s3_rawp_reg;

    logic signed [31:0] bb_sh;
    logic signed [47:0] x_full;

    assign bb_sh  = s1_bb_reg >>> 11'd12;
    assign x_full = bb_sh * t3;

    // pressure stages
    logic signed [33:0] v1_n;
    logic signed [35:0] tc_full, tc_sh;

    assign v1_n    = {{2{s3_fine_reg[31]}}, s3_fine_reg} - 34'sd128000;
    assign tc_full = {{4{s3_fine_reg[31]}}, s3_fine_reg} * 36'sd5 + 36'sd128;
    assign tc_sh   = tc_full >>> 8;

    logic signed [33:0] s4_v1_reg;
    logic [31:0]        s4_tc_reg, s4_fine_reg;
    logic [19:0]        s4_rawp_reg;

    logic signed [67:0] vv_full;
    logic signed [49:0] pv5_n, pv2_n;

    assign vv_full = s4_v1_reg * s4_v1_reg;
    assign pv5_n   = s4_v1_reg * p5;
    assign pv2_n   = s4_v1_reg * p2;

    logic signed [63:0] s5_vv_reg;
    logic signed [49:0] s5_pv5_reg, s5_pv2_reg;
    logic [31:0]        s5_tc_reg, s5_fine_reg;
    logic [19:0]        s5_rawp_reg;

    logic signed [79:0] t6_full, t3v_full;

    assign t6_full  = s5_vv_reg * p6;
    assign t3v_full = s5_vv_reg * p3;

    logic signed [63:0] s6_t6_reg, s6_t3v_reg;
    logic signed [49:0] s6_pv5_reg, s6_pv2_reg;
    logic [31:0]        s6_tc_reg, s6_fine_reg;
    logic [19:0]        s6_rawp_reg;

    logic signed [63:0] v2_n, v1a_n;

    always_comb
    begin
        v2_n  = s6_t6_reg + ({{14{s6_pv5_reg[49]}}, s6_pv5_reg} <<< 17)
              + {{13{p4[15]}}, p4, 35'b0};
        v1a_n = (s6_t3v_reg >>> 8)
              + (signed'({{14{s6_pv2_reg[49]}}, s6_pv2_reg}) <<< 12);
    end

    logic [63:0] s7_v2_reg, s7_v1a_reg;
    logic [31:0] s7_tc_reg, s7_fine_reg;
    logic [19:0] s7_rawp_reg;

    logic [63:0] v1c;
    logic [79:0] v1b_full;
    logic [20:0] pm;

    always_comb
    begin
        v1c      = s7_v1a_reg + 64'h0000_8000_0000_0000;
        v1b_full = v1c * p1;
        pm       = 21'd1048576 - {1'b0, s7_rawp_reg};
    end

    logic [DivW-1:0] s8_d_reg;
    logic [63:0]     s8_nd_reg;
    logic [31:0]     s8_tc_reg, s8_fine_reg;

    logic [75:0] n_full;

    assign n_full = s8_nd_reg * 12'd3125;

    logic [63:0]     s9_n_reg;
    logic [DivW-1:0] s9_ud_reg;
    logic            s9_dneg_reg, s9_zero_reg;
    logic [31:0]     s9_tc_reg, s9_fine_reg;

    div_stage_t s10_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ta_reg   <= ta_full[31:0];
            s1_bb_reg   <= bb_full[31:0];
            s1_rawp_reg <= raw_p;

            s2_tv1_reg  <= s1_ta_reg >>> 11;
            s2_x_reg    <= x_full[31:0];
            s2_rawp_reg <= s1_rawp_reg;

            s3_fine_reg <= s2_tv1_reg + (s2_x_reg >>> 14);
            s3_rawp_reg <= s2_rawp_reg;

            s4_v1_reg   <= v1_n;
            s4_tc_reg   <= tc_sh[31:0];
            s4_fine_reg <= s3_fine_reg;
            s4_rawp_reg <= s3_rawp_reg;

            s5_vv_reg   <= vv_full[63:0];
            s5_pv5_reg  <= pv5_n;
            s5_pv2_reg  <= pv2_n;
            s5_tc_reg   <= s4_tc_reg;
            s5_fine_reg <= s4_fine_reg;
            s5_rawp_reg <= s4_rawp_reg;

            s6_t6_reg   <= t6_full[63:0];
            s6_t3v_reg  <= t3v_full[63:0];
            s6_pv5_reg  <= s5_pv5_reg;
            s6_pv2_reg  <= s5_pv2_reg;
            s6_tc_reg   <= s5_tc_reg;
            s6_fine_reg <= s5_fine_reg;
            s6_rawp_reg <= s5_rawp_reg;

            s7_v2_reg   <= v2_n;
            s7_v1a_reg  <= v1a_n;
            s7_tc_reg   <= s6_tc_reg;
            s7_fine_reg <= s6_fine_reg;
            s7_rawp_reg <= s6_rawp_reg;

            s8_d_reg    <= v1b_full[63:33];
            s8_nd_reg   <= {12'b0, pm, 31'b0} - s7_v2_reg;
            s8_tc_reg   <= s7_tc_reg;
            s8_fine_reg <= s7_fine_reg;

            s9_n_reg    <= n_full[63:0];
            s9_dneg_reg <= s8_d_reg[DivW-1];
            s9_zero_reg <= s8_d_reg == '0;
            s9_ud_reg   <= s8_d_reg[DivW-1] ? (~s8_d_reg + 1'b1) : s8_d_reg;
            s9_tc_reg   <= s8_tc_reg;
            s9_fine_reg <= s8_fine_reg;

            s10_reg.rem       <= '0;
            s10_reg.ud        <= s9_ud_reg;
            s10_reg.nq        <= s9_n_reg[63] ? (~s9_n_reg + 1'b1) : s9_n_reg;
            s10_reg.side.fine <= s9_fine_reg;
            s10_reg.side.tc   <= s9_tc_reg;
            s10_reg.side.zero <= s9_zero_reg;
            s10_reg.side.qneg <= s9_n_reg[63] ^ s9_dneg_reg;
        end
    end

    div_stage_t div_out;

    btpc_divider u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (pre_vld_reg[9]),
        .in_st   (s10_reg),
        .out_vld (div_out_vld),
        .out_st  (div_out)
    );

    // correction terms after the division
    logic signed [63:0] pa_reg;
    side_t              pa_side_reg;

    logic signed [63:0] q13;
    logic [63:0]        m0_n;
    logic [63:0]        m1_full;
    logic signed [79:0] w2p_full;

    always_comb
    begin
        q13      = pa_reg >>> 13;
        m0_n     = q13[31:0] * q13[31:0];
        m1_full  = q13[63:32] * q13[31:0];
        w2p_full = pa_reg * p8;
    end

    logic [63:0]        pb_m0_reg;
    logic [31:0]        pb_m1_reg;
    logic signed [63:0] pb_w2p_reg, pb_p_reg;
    side_t              pb_side_reg;

    logic signed [63:0] pc_sq_reg, pc_w2_reg, pc_p_reg;
    side_t              pc_side_reg;

    logic signed [79:0] w1p_full;

    assign w1p_full = pc_sq_reg * p9;

    logic signed [63:0] pd_w1p_reg, pd_w2_reg, pd_p_reg;
    side_t              pd_side_reg;

    logic signed [63:0] pe_s_reg;
    side_t              pe_side_reg;

    logic signed [63:0] s_sh;
    logic [31:0]        press_n;

    assign s_sh    = pe_s_reg >>> 8;
    assign press_n = s_sh[31:0] + {{12{p7[15]}}, p7, 4'b0};

    logic [31:0] out_tc_reg, out_fine_reg, out_press_reg;
    logic        out_pvalid_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg      <= div_out.side.qneg ? signed'(~div_out.nq + 1'b1)
                                             : signed'(div_out.nq);
            pa_side_reg <= div_out.side;

            pb_m0_reg   <= m0_n;
            pb_m1_reg   <= m1_full[31:0];
            pb_w2p_reg  <= w2p_full[63:0];
            pb_p_reg    <= pa_reg;
            pb_side_reg <= pa_side_reg;

            pc_sq_reg   <= signed'(pb_m0_reg + {pb_m1_reg[30:0], 1'b0, 32'b0});
            pc_w2_reg   <= pb_w2p_reg >>> 19;
            pc_p_reg    <= pb_p_reg;
            pc_side_reg <= pb_side_reg;

            pd_w1p_reg  <= w1p_full[63:0];
            pd_w2_reg   <= pc_w2_reg;
            pd_p_reg    <= pc_p_reg;
            pd_side_reg <= pc_side_reg;

            pe_s_reg    <= pd_p_reg + (pd_w1p_reg >>> 25) + pd_w2_reg;
            pe_side_reg <= pd_side_reg;

            if (post_vld_reg[4])
            begin
                out_tc_reg     <= pe_side_reg.tc;
                out_fine_reg   <= pe_side_reg.fine;
                out_press_reg  <= pe_side_reg.zero ? 32'd0 : press_n;
                out_pvalid_reg <= ~pe_side_reg.zero;
            end
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {out_press_reg, out_fine_reg, out_tc_reg};
    assign m_axis_tuser  = out_pvalid_reg;

`ifndef SYNTHESIS
    a_invalid_press_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[95:64] == 32'd0)
        else $error("invalid pressure result is not zero");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output register");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready && post_vld_reg[4] |-> !en)
        else $error("pending result would be overwritten");
`endif

endmodule

// ----- hdl/btpc_div_cell.sv -----
`timescale 1ns / 1ps

module btpc_div_cell
    import btpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_vld,
    input  div_stage_t in_st,
    output logic       out_vld,
    output div_stage_t out_st
);

    logic            vld_reg;
    div_stage_t      st_reg;
    div_stage_t      st_next;
    logic [DivW:0]   trial;
    logic [DivW:0]   diff;
    logic            ge;

    always_comb
    begin
        trial   = {in_st.rem, in_st.nq[DivBits-1]};
        ge      = trial >= {1'b0, in_st.ud};
        diff    = trial - {1'b0, in_st.ud};
        st_next = in_st;
        st_next.rem = ge ? diff[DivW-1:0] : trial[DivW-1:0];
        st_next.nq  = {in_st.nq[DivBits-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign out_vld = vld_reg;
    assign out_st  = st_reg;

endmodule

// ----- hdl/btpc_divider.sv -----
`timescale 1ns / 1ps

module btpc_divider
    import btpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_vld,
    input  div_stage_t in_st,
    output logic       out_vld,
    output div_stage_t out_st
);

    logic       vld [0:DivBits];
    div_stage_t st  [0:DivBits];

    assign vld[0] = in_vld;
    assign st[0]  = in_st;

    for (genvar i = 0; i < DivBits; i++)
    begin : g_cell
        btpc_div_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .in_vld  (vld[i]),
            .in_st   (st[i]),
            .out_vld (vld[i+1]),
            .out_st  (st[i+1])
        );
    end

    assign out_vld = vld[DivBits];
    assign out_st  = st[DivBits];

endmodule
